/* rtl/mm4_pkg.sv */
package mm4_pkg;

    // Element width and command queue depth defaults
    localparam int ELEM_WIDTH_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fraction bits after reset
    localparam logic [4:0] FRAC_BITS_RESET = 5'd16;

    // Request codes
    localparam logic [1:0] REQ_WRITE_A  = 2'd0;
    localparam logic [1:0] REQ_WRITE_B  = 2'd1;
    localparam logic [1:0] REQ_MULTIPLY = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [3:0]         out_index;
        logic signed [31:0] out_value;
        logic               saturated;
        logic               last_out;
    } t_out_word;

    // Head of the command queue as seen by the execution side
    typedef struct packed {
        logic     valid;
        t_in_word cmd;
    } t_queue_head;

endpackage

/* rtl/mm4_front.sv */
module mm4_front #(
    parameter int QUEUE_DEPTH = mm4_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mm4_pkg::t_in_word     i_in,
    output mm4_pkg::t_queue_head  o_head,
    input  logic                  i_pop
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

    mm4_pkg::t_in_word r_q [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;
    logic [PtrW-1:0]   n_wr;
    logic [PtrW-1:0]   n_rd;
    logic [CntW-1:0]   n_cnt;
    logic              accept;
    logic              push;
    logic              pop;

    // Take a word when not full; drop unused request codes
    assign o_in_stall = (r_cnt == CntFull);
    assign accept     = i_in_valid && !o_in_stall;
    assign push       = accept && (i_in.req_type == mm4_pkg::REQ_WRITE_A ||
                                   i_in.req_type == mm4_pkg::REQ_WRITE_B ||
                                   i_in.req_type == mm4_pkg::REQ_MULTIPLY);
    assign pop        = i_pop && (r_cnt != '0);

    // Present the oldest command
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rd];

    // Advance pointers and fill level
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the command word
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_in;
        end
    end

endmodule

/* rtl/mm4_back.sv */
module mm4_back #(
    parameter int ELEM_WIDTH = mm4_pkg::ELEM_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mm4_pkg::t_queue_head  i_head,
    output logic                  o_pop,
    input  logic [4:0]            i_frac_bits,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mm4_pkg::t_out_word    o_out
);

    localparam int ProdW = 2 * ELEM_WIDTH;
    localparam int AccW  = 2 * ELEM_WIDTH + 2;
    localparam logic signed [AccW-1:0] MaxVal =
        {{(AccW - ELEM_WIDTH + 1){1'b0}}, {(ELEM_WIDTH - 1){1'b1}}};
    localparam logic signed [AccW-1:0] MinVal =
        {{(AccW - ELEM_WIDTH + 1){1'b1}}, {(ELEM_WIDTH - 1){1'b0}}};

    logic [ELEM_WIDTH-1:0]        r_a [16];
    logic [ELEM_WIDTH-1:0]        r_b [16];
    logic                         r_busy;
    logic [5:0]                   r_cnt;
    logic                         r_s1_v;
    logic [5:0]                   r_s1_tag;
    logic signed [ELEM_WIDTH-1:0] r_opa;
    logic signed [ELEM_WIDTH-1:0] r_opb;
    logic                         r_s2_v;
    logic [5:0]                   r_s2_tag;
    logic signed [ProdW-1:0]      r_prod;
    logic                         r_s3_v;
    logic [3:0]                   r_s3_e;
    logic signed [AccW-1:0]       r_acc;
    logic                         r_s4_v;
    logic [3:0]                   r_s4_e;
    logic signed [AccW-1:0]       r_shf;
    logic                         r_out_valid;
    mm4_pkg::t_out_word           r_out;
    mm4_pkg::t_out_word           n_out;
    logic signed [ELEM_WIDTH-1:0] sat_val;
    logic                         en;
    logic                         wr_a;
    logic                         wr_b;
    logic                         start;
    logic                         issue;
    logic [3:0]                   a_idx;
    logic [3:0]                   b_idx;

    // Whole pipeline holds while the output word waits
    assign en = !(r_out_valid && i_out_stall);

    // Execute queued commands; a multiply blocks the queue until all reads issue
    assign o_pop = i_head.valid && !r_busy;
    assign wr_a  = o_pop && (i_head.cmd.req_type == mm4_pkg::REQ_WRITE_A);
    assign wr_b  = o_pop && (i_head.cmd.req_type == mm4_pkg::REQ_WRITE_B);
    assign start = o_pop && (i_head.cmd.req_type == mm4_pkg::REQ_MULTIPLY);
    assign issue = r_busy && en;

    // Element e = r_cnt[5:2] (row r_cnt[5:4], column r_cnt[3:2]), term k = r_cnt[1:0]
    assign b_idx = {r_cnt[5:4], r_cnt[1:0]};
    assign a_idx = {r_cnt[1:0], r_cnt[3:2]};

    // Element stores, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_a[i] <= '0;
                r_b[i] <= '0;
            end
        end else begin
            if (wr_a) begin
                r_a[i_head.cmd.elem_index] <= i_head.cmd.elem_value[ELEM_WIDTH-1:0];
            end
            if (wr_b) begin
                r_b[i_head.cmd.elem_index] <= i_head.cmd.elem_value[ELEM_WIDTH-1:0];
            end
        end
    end

    // Step through 16 elements times 4 terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (issue) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_v      <= issue;
            r_s2_v      <= r_s1_v;
            r_s3_v      <= r_s2_v && (r_s2_tag[1:0] == 2'd3);
            r_s4_v      <= r_s3_v;
            r_out_valid <= r_s4_v;
        end
    end

    // Read operands, multiply, accumulate, scale, saturate
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_opa    <= r_a[a_idx];
            r_opb    <= r_b[b_idx];
            r_s1_tag <= r_cnt;
        end
        if (en && r_s1_v) begin
            r_prod   <= r_opb * r_opa;
            r_s2_tag <= r_s1_tag;
        end
        if (en && r_s2_v) begin
            if (r_s2_tag[1:0] == 2'd0) begin
                r_acc <= AccW'(r_prod);
            end else begin
                r_acc <= r_acc + AccW'(r_prod);
            end
            r_s3_e <= r_s2_tag[5:2];
        end
        if (en && r_s3_v) begin
            r_shf  <= r_acc >>> i_frac_bits;
            r_s4_e <= r_s3_e;
        end
        if (en && r_s4_v) begin
            r_out <= n_out;
        end
    end

    // Clip the scaled sum to the element range
    always_comb begin
        n_out           = '0;
        n_out.out_index = r_s4_e;
        n_out.last_out  = (r_s4_e == 4'd15);
        if (r_shf > MaxVal) begin
            sat_val         = MaxVal[ELEM_WIDTH-1:0];
            n_out.saturated = 1'b1;
        end else if (r_shf < MinVal) begin
            sat_val         = MinVal[ELEM_WIDTH-1:0];
            n_out.saturated = 1'b1;
        end else begin
            sat_val         = r_shf[ELEM_WIDTH-1:0];
            n_out.saturated = 1'b0;
        end
        n_out.out_value = 32'(sat_val);
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The sequencer leaves busy only after its last read
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) && $past(i_rst_n) |-> $past(r_cnt) == 6'd63)
        else $error("sequencer stopped early");

    // Stores are not written while a multiply still reads them
    a_no_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_a || wr_b) |-> !r_busy)
        else $error("store written during multiply");

    // A clipped word carries a range bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.saturated |->
            o_out.out_value == 32'($signed(MaxVal[ELEM_WIDTH-1:0])) ||
            o_out.out_value == 32'($signed(MinVal[ELEM_WIDTH-1:0])))
        else $error("saturated word not at bound");

    // Words of one product leave in row-major order
    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out.last_out |=>
            !o_out_valid || o_out.out_index == $past(o_out.out_index) + 4'd1)
        else $error("product element out of order");

endmodule

/* rtl/matrix4x4_multiply_core.sv */
// 4x4 fixed-point matrix multiplier.
// Input channel (i_in_valid / o_in_stall, word i_in): a word writes one
// element of A or B at a row-major index, or requests a multiply; the unused
// request code is taken and dropped. Output channel (o_out_valid / i_out_stall,
// word o_out): a multiply yields 16 words in row-major order, element
// out[r][c] = sum over k of B[r][k]*A[k][c], shifted right by frac_bits and
// clipped to the element range, with last_out on the sixteenth word.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes frac_bits;
// write it only while the block is idle.
// Accepted words enter a short command queue; writes execute one per cycle
// while no multiply is running. A multiply runs its 64 partial products through
// the single multiplier, one per cycle while the output is not stalled; each
// result word sums four of them. A stall on the output holds the whole
// execution pipeline; the queue keeps taking words until it fills. Synchronous
// reset clears both stores to zero, sets frac_bits to 16 and empties the queue
// and pipeline.
module matrix4x4_multiply_core #(
    parameter int ELEM_WIDTH  = mm4_pkg::ELEM_WIDTH_DEF,
    parameter int QUEUE_DEPTH = mm4_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mm4_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mm4_pkg::t_out_word o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_data
);

    logic                 [4:0] r_frac_bits;
    mm4_pkg::t_queue_head       head;
    logic                       pop;

    // Fraction bits register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_bits <= mm4_pkg::FRAC_BITS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_frac_bits <= i_cfg_data;
        end
    end

    // Accept and queue commands
    mm4_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_head     (head),
        .i_pop      (pop)
    );

    // Execute writes and multiplies
    mm4_back #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .i_frac_bits (r_frac_bits),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

/* verif/matrix4x4_multiply_core_tb.sv */
module matrix4x4_multiply_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ELEM_W     = mm4_pkg::ELEM_WIDTH_DEF;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam logic [31:0] ELEM_MIN   = 32'h8000_0000;
    localparam logic [31:0] ELEM_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] ELEM_M1    = 32'hFFFF_FFFF;
    localparam logic signed [67:0] SAT_MAX = (68'sd1 <<< (ELEM_W - 1)) - 68'sd1;
    localparam logic signed [67:0] SAT_MIN = -(68'sd1 <<< (ELEM_W - 1));
    localparam int SETTLE_CYCLES = 100;
    localparam int ROUNDS        = 8;
    localparam int ROUND_WORDS   = 52;
    localparam int DIR_N         = 24;

    // One directed row; typed rows expect e0_val at element 0 and zero elsewhere
    typedef struct packed {
        logic [1:0]  req;
        logic [3:0]  idx;
        logic [31:0] val;
        logic        typed;
        logic [31:0] e0_val;
        logic        e0_sat;
    } t_dir_row;

    t_dir_row dir_tab [0:DIR_N-1] = '{
        '{mm4_pkg::REQ_MULTIPLY, 4'd0,  32'd0,         1'b1, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_A,  4'd0,  ELEM_MIN,      1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_B,  4'd0,  ELEM_MIN,      1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_MULTIPLY, 4'd0,  32'd0,         1'b1, ELEM_MAX, 1'b1},
        '{mm4_pkg::REQ_WRITE_A,  4'd0,  ELEM_MAX,      1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_MULTIPLY, 4'd0,  32'd0,         1'b1, ELEM_MIN, 1'b1},
        '{mm4_pkg::REQ_WRITE_B,  4'd0,  ELEM_MAX,      1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_MULTIPLY, 4'd0,  32'd0,         1'b1, ELEM_MAX, 1'b1},
        '{mm4_pkg::REQ_WRITE_A,  4'd0,  32'd1,         1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_B,  4'd0,  32'd1,         1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_MULTIPLY, 4'd0,  32'd0,         1'b1, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_A,  4'd0,  ELEM_M1,       1'b0, 32'd0,    1'b0},
        '{REQ_UNUSED,            4'd0,  ELEM_MAX,      1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_MULTIPLY, 4'd0,  32'd0,         1'b1, ELEM_M1,  1'b0},
        '{mm4_pkg::REQ_WRITE_A,  4'd15, 32'h0001_8000, 1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_B,  4'd15, 32'hFFFE_4000, 1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_B,  4'd12, 32'h0003_0000, 1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_A,  4'd3,  32'h7FFF_0000, 1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_A,  4'd12, 32'h8000_FFFF, 1'b0, 32'd0,    1'b0},
        '{REQ_UNUSED,            4'd15, ELEM_MIN,      1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_MULTIPLY, 4'd15, ELEM_M1,       1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_B,  4'd3,  32'h0000_0001, 1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_WRITE_A,  4'd5,  ELEM_MIN,      1'b0, 32'd0,    1'b0},
        '{mm4_pkg::REQ_MULTIPLY, 4'd9,  32'h1234_5678, 1'b0, 32'd0,    1'b0}
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    mm4_pkg::t_in_word  i_in        = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [4:0]         i_cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    mm4_pkg::t_out_word o_out;
    logic               o_cfg_ready;

    // Shadow copy of the block state
    logic [31:0] a_mat [16];
    logic [31:0] b_mat [16];
    logic [4:0]  frac_q;

    mm4_pkg::t_out_word prod_q[$];
    mm4_pkg::t_out_word want;
    int                 err_cnt   = 0;
    int                 idle_pct  = 0;
    int                 stall_pct = 0;

    matrix4x4_multiply_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the output at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("matrix4x4_multiply_core_tb: done, errors");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    // Read back a stored element at the element width, sign extended
    function automatic logic signed [63:0] elem_val(logic [31:0] raw);
        logic signed [63:0] x;
        x = {{32{raw[31]}}, raw};
        return (x <<< (64 - ELEM_W)) >>> (64 - ELEM_W);
    endfunction

    // One product element: exact dot product, floor shift, clip
    function automatic mm4_pkg::t_out_word mat_elem(int e);
        int                 r;
        int                 c;
        int                 k;
        logic signed [67:0] acc;
        logic signed [67:0] sh;
        mm4_pkg::t_out_word o;
        r   = e / 4;
        c   = e % 4;
        acc = '0;
        for (k = 0; k < 4; k++) begin
            acc = acc + elem_val(b_mat[r * 4 + k]) * elem_val(a_mat[k * 4 + c]);
        end
        sh          = acc >>> frac_q;
        o.out_index = 4'(e);
        o.last_out  = (e == 15);
        if (sh > SAT_MAX) begin
            o.out_value = SAT_MAX[31:0];
            o.saturated = 1'b1;
        end else if (sh < SAT_MIN) begin
            o.out_value = SAT_MIN[31:0];
            o.saturated = 1'b1;
        end else begin
            o.out_value = sh[31:0];
            o.saturated = 1'b0;
        end
        return o;
    endfunction

    // Apply an accepted input word to the shadow state
    task automatic load_word(mm4_pkg::t_in_word w);
        int e;
        case (w.req_type)
            mm4_pkg::REQ_WRITE_A: begin
                a_mat[w.elem_index] = w.elem_value;
            end
            mm4_pkg::REQ_WRITE_B: begin
                b_mat[w.elem_index] = w.elem_value;
            end
            mm4_pkg::REQ_MULTIPLY: begin
                for (e = 0; e < 16; e++) begin
                    prod_q.insert(prod_q.size(), mat_elem(e));
                end
            end
            default: begin
                // unused code: dropped
            end
        endcase
    endtask

    // Queue a product known by inspection: e0 at element 0, zeros elsewhere
    task automatic push_typed(logic [31:0] e0, logic s0);
        int                 e;
        mm4_pkg::t_out_word o;
        for (e = 0; e < 16; e++) begin
            o.out_index = 4'(e);
            o.out_value = (e == 0) ? e0 : 32'd0;
            o.saturated = (e == 0) ? s0 : 1'b0;
            o.last_out  = (e == 15);
            prod_q.insert(prod_q.size(), o);
        end
    endtask

    // Offer one word, return at the edge that takes it
    task automatic send_word(mm4_pkg::t_in_word w);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // Drain all products, then let trailing writes retire
    task automatic settle();
        i_in_valid <= 1'b0;
        while (prod_q.size() != 0) begin
            @(negedge i_clk);
        end
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_frac(logic [4:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        frac_q = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_elem();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            return $urandom;
        end else if (sel < 80) begin
            return 32'($signed($urandom) >>> $urandom_range(4, 31));
        end
        case ($urandom_range(0, 4))
            0:       return ELEM_MIN;
            1:       return ELEM_MAX;
            2:       return 32'd0;
            3:       return 32'd1;
            default: return ELEM_M1;
        endcase
    endfunction

    function automatic mm4_pkg::t_in_word rand_word();
        mm4_pkg::t_in_word w;
        int                sel;
        sel          = $urandom_range(0, 99);
        w.req_type   = (sel < 42) ? mm4_pkg::REQ_WRITE_A :
                       (sel < 84) ? mm4_pkg::REQ_WRITE_B :
                       (sel < 96) ? mm4_pkg::REQ_MULTIPLY : REQ_UNUSED;
        w.elem_index = 4'($urandom_range(0, 15));
        w.elem_value = rand_elem();
        return w;
    endfunction

    // Check each output word against the oldest expected product element
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (prod_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word at index %0d", o_out.out_index));
            end else begin
                want = prod_q.pop_front();
                if (o_out.out_index !== want.out_index) begin
                    report_mismatch($sformatf("out_index %0d, want %0d",
                                              o_out.out_index, want.out_index));
                end
                if (o_out.out_value !== want.out_value) begin
                    report_mismatch($sformatf("index %0d out_value %h, want %h",
                                              want.out_index, o_out.out_value,
                                              want.out_value));
                end
                if (o_out.saturated !== want.saturated) begin
                    report_mismatch($sformatf("index %0d saturated %b, want %b",
                                              want.out_index, o_out.saturated,
                                              want.saturated));
                end
                if (o_out.last_out !== want.last_out) begin
                    report_mismatch($sformatf("index %0d last_out %b, want %b",
                                              want.out_index, o_out.last_out,
                                              want.last_out));
                end
            end
        end
    end

    // Main sequence
    initial begin
        int                i;
        int                rnd;
        mm4_pkg::t_in_word w;
        logic [4:0]        fb;

        for (i = 0; i < 16; i++) begin
            a_mat[i] = '0;
            b_mat[i] = '0;
        end
        frac_q = mm4_pkg::FRAC_BITS_RESET;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rows at the reset frac_bits, no idling
        for (i = 0; i < DIR_N; i++) begin
            w.req_type   = dir_tab[i].req;
            w.elem_index = dir_tab[i].idx;
            w.elem_value = dir_tab[i].val;
            send_word(w);
            if (dir_tab[i].typed) begin
                push_typed(dir_tab[i].e0_val, dir_tab[i].e0_sat);
            end else begin
                load_word(w);
            end
            @(negedge i_clk);
        end
        settle();

        // Random rounds: new frac_bits and idling and stalling mode for each
        for (rnd = 0; rnd < ROUNDS; rnd++) begin
            case (rnd)
                0:       fb = 5'd0;
                1:       fb = 5'd31;
                2:       fb = 5'd30;
                3:       fb = 5'd16;
                4:       fb = 5'd1;
                7:       fb = 5'd24;
                default: fb = 5'($urandom_range(2, 29));
            endcase
            write_frac(fb);
            case (rnd % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 69; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 69; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            for (i = 0; i < ROUND_WORDS; i++) begin
                w = rand_word();
                send_word(w);
                load_word(w);
                @(negedge i_clk);
            end
            settle();
        end

        if (err_cnt == 0) begin
            $display("matrix4x4_multiply_core_tb: done, clean");
        end else begin
            $display("matrix4x4_multiply_core_tb: done, errors");
        end
        $finish;
    end

endmodule
